// File: rtl/mdlp_pkg.sv
// Package with the shared types, character codes and limits of the meter data-line parser.
`default_nettype none

package mdlp_pkg;

    // Fixed sizes of the code slots and identifiers.
    localparam int CODE_SLOTS   = 4;
    localparam int ID_MAX_CHARS = 8;
    localparam int ID_W         = ID_MAX_CHARS * 8;
    localparam int ID_LEN_W     = 4;
    localparam logic [ID_LEN_W-1:0] ID_LEN_BAD = 4'd15;

    // Depth of the queue between the classifying front and the parsing back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_CODE_COUNT = 3'd0;
    localparam int         CFG_CODE_BASE  = 1;

    // Magnitude limit of the number accumulator and the saturation test.
    localparam logic [31:0] MAG_LIMIT    = 32'h8000_0000;
    localparam logic [31:0] ACC_THRESH   = MAG_LIMIT / 10;
    localparam logic [3:0]  DIGIT_LIMIT  = 4'(MAG_LIMIT % 10);
    localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
    localparam logic [3:0]  DEC_MAX      = 4'd15;

    // Character codes.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_OPEN    = 8'h28;
    localparam logic [7:0] CH_CLOSE   = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // Class of one byte as decided by the front.
    typedef enum logic [3:0] {
        CLS_NEWLINE = 4'd0,
        CLS_COLON   = 4'd1,
        CLS_OPEN    = 4'd2,
        CLS_CLOSE   = 4'd3,
        CLS_STAR    = 4'd4,
        CLS_DOT     = 4'd5,
        CLS_DIGIT   = 4'd6,
        CLS_SPACE   = 4'd7,
        CLS_PLUS    = 4'd8,
        CLS_MINUS   = 4'd9,
        CLS_NUL     = 4'd10,
        CLS_OTHER   = 4'd11
    } byte_class_t;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
    } byte_item_t;

    // Where the parser stands within a line.
    typedef enum logic [4:0] {
        PH_PREFIX = 5'b00001,
        PH_ID     = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_AFTER  = 5'b01000,
        PH_REJECT = 5'b10000
    } line_phase_t;

    // Where the number reader stands within the value.
    typedef enum logic [2:0] {
        NUM_BEFORE = 3'b001,
        NUM_IN     = 3'b010,
        NUM_STOP   = 3'b100
    } number_phase_t;

endpackage

`default_nettype wire

// File: rtl/mdlp_byte_if.sv
// Channel that carries one data byte per item.
`default_nettype none

interface mdlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/mdlp_result_if.sv
// Channel that carries one parsed line result per item.
`default_nettype none

interface mdlp_result_if;
    logic               valid;
    logic               ready;
    logic               line_matched;
    logic [1:0]         channel;
    logic signed [31:0] reading;
    logic [3:0]         decimals;
    logic [3:0]         present_mask;

    modport source (output valid, output line_matched, output channel, output reading,
                     output decimals, output present_mask, input ready);
    modport sink (input valid, input line_matched, input channel, input reading,
                   input decimals, input present_mask, output ready);
endinterface

`default_nettype wire

// File: rtl/mdlp_cfg_if.sv
// Configuration write channel with register index and write data.
`default_nettype none

interface mdlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/mdlp_front.sv
// Front end: accepts data bytes and classifies each one for the parser.
`default_nettype none

module mdlp_front
    import mdlp_pkg::*;
(
    mdlp_byte_if.sink  bytes_in,
    output logic       push_valid,
    input  logic       push_ready,
    output byte_item_t push_item
);

    byte_class_t cls;
    logic [7:0]  b;

    assign b = bytes_in.data_byte;

    // Sort the byte into the classes that the parser acts upon.
    always_comb
    begin
        if (b == CH_NEWLINE)
            cls = CLS_NEWLINE;
        else if (b == CH_COLON)
            cls = CLS_COLON;
        else if (b == CH_OPEN)
            cls = CLS_OPEN;
        else if (b == CH_CLOSE)
            cls = CLS_CLOSE;
        else if (b == CH_STAR)
            cls = CLS_STAR;
        else if (b == CH_DOT)
            cls = CLS_DOT;
        else if (b >= CH_ZERO && b <= CH_NINE)
            cls = CLS_DIGIT;
        else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
            cls = CLS_SPACE;
        else if (b == CH_PLUS)
            cls = CLS_PLUS;
        else if (b == CH_MINUS)
            cls = CLS_MINUS;
        else if (b == CH_NUL)
            cls = CLS_NUL;
        else
            cls = CLS_OTHER;
    end

    // The item goes straight into the queue whenever it has room.
    assign push_valid     = bytes_in.valid;
    assign bytes_in.ready = push_ready;
    assign push_item.data = b;
    assign push_item.cls  = cls;

endmodule

`default_nettype wire

// File: rtl/mdlp_queue.sv
// Short queue of classified bytes between the front and the parser.
`default_nettype none

module mdlp_queue
    import mdlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  byte_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output byte_item_t pop_item
);

    byte_item_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed on the payload.
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// File: rtl/mdlp_back.sv
// Back end: line parser, code slot registers, identifier match and result register.
`default_nettype none

module mdlp_back
    import mdlp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    output logic            head_ready,
    input  byte_item_t      head_item,
    mdlp_cfg_if.sink        cfg,
    mdlp_result_if.source   results
);

    // Configuration registers.
    logic [2:0]      code_count_reg;
    logic [ID_W-1:0] code_reg [CODE_SLOTS];

    // Line state.
    line_phase_t          line_phase_reg, line_phase_next;
    logic [ID_W-1:0]      id_chars_reg, id_chars_next;
    logic [ID_LEN_W-1:0]  id_length_reg, id_length_next;
    logic [31:0]          value_acc_reg, value_acc_next;
    logic                 value_negative_reg, value_negative_next;
    number_phase_t        number_phase_reg, number_phase_next;
    logic                 dot_seen_reg, dot_seen_next;
    logic [3:0]           decimal_count_reg, decimal_count_next;
    logic                 close_seen_reg, close_seen_next;
    logic [CODE_SLOTS-1:0] present_bits_reg, present_bits_next;

    // Result register.
    logic               res_valid_reg, res_valid_next;
    logic               res_matched_reg;
    logic [1:0]         res_channel_reg;
    logic [31:0]        res_reading_reg;
    logic [3:0]         res_decimals_reg;
    logic [3:0]         res_mask_reg;

    logic               out_free;
    logic               pop;
    logic               is_newline;
    logic               hit;
    logic [1:0]         slot;
    logic [31:0]        reading;
    logic [3:0]         digit;
    logic [31:0]        acc_added;
    logic               acc_sat;

    assign cfg.ready  = 1'b1;
    assign is_newline = (head_item.cls == CLS_NEWLINE);
    assign out_free   = !res_valid_reg || results.ready;
    assign head_ready = !is_newline || out_free;
    assign pop        = head_valid && head_ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_count_reg <= '0;
            for (int i = 0; i < CODE_SLOTS; i++)
                code_reg[i] <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_CODE_COUNT)
                code_count_reg <= cfg.data[2:0];
            for (int i = 0; i < CODE_SLOTS; i++)
            begin
                if (cfg.index == 3'(CFG_CODE_BASE + i))
                    code_reg[i] <= cfg.data;
            end
        end
    end

    // Identifier match: the lowest slot in use that equals the identifier wins.
    always_comb
    begin
        hit  = 1'b0;
        slot = '0;
        if (close_seen_reg && id_length_reg <= ID_LEN_W'(ID_MAX_CHARS))
        begin
            for (int i = CODE_SLOTS - 1; i >= 0; i--)
            begin
                if (code_count_reg > 3'(i) && code_reg[i] == id_chars_reg)
                begin
                    hit  = 1'b1;
                    slot = 2'(i);
                end
            end
        end
    end

    // Signed reading from the magnitude and sign.
    always_comb
    begin
        if (value_negative_reg)
            reading = 32'd0 - value_acc_reg;
        else if (value_acc_reg[31])
            reading = POS_MAX;
        else
            reading = value_acc_reg;
    end

    // One decimal digit into the accumulator, saturating at the magnitude limit.
    assign digit     = head_item.data[3:0];
    assign acc_sat   = (value_acc_reg > ACC_THRESH) ||
                       (value_acc_reg == ACC_THRESH && digit > DIGIT_LIMIT);
    assign acc_added = {value_acc_reg[28:0], 3'b000} + {value_acc_reg[30:0], 1'b0} +
                       {28'd0, digit};

    // Per-byte update of the line state.
    always_comb
    begin
        line_phase_next     = line_phase_reg;
        id_chars_next       = id_chars_reg;
        id_length_next      = id_length_reg;
        value_acc_next      = value_acc_reg;
        value_negative_next = value_negative_reg;
        number_phase_next   = number_phase_reg;
        dot_seen_next       = dot_seen_reg;
        decimal_count_next  = decimal_count_reg;
        close_seen_next     = close_seen_reg;
        present_bits_next   = present_bits_reg;

        if (pop)
        begin
            if (is_newline)
            begin
                // End of line: record the match and start afresh.
                if (hit)
                    present_bits_next = present_bits_reg | (CODE_SLOTS'(1) << slot);
                line_phase_next     = PH_PREFIX;
                id_chars_next       = '0;
                id_length_next      = '0;
                value_acc_next      = '0;
                value_negative_next = 1'b0;
                number_phase_next   = NUM_BEFORE;
                dot_seen_next       = 1'b0;
                decimal_count_next  = '0;
                close_seen_next     = 1'b0;
            end
            else
            begin
                case (line_phase_reg)
                    PH_PREFIX:
                    begin
                        if (head_item.cls == CLS_COLON)
                            line_phase_next = PH_ID;
                        else if (head_item.cls == CLS_OPEN)
                            line_phase_next = PH_REJECT;
                    end
                    PH_ID:
                    begin
                        if (head_item.cls == CLS_OPEN)
                            line_phase_next = PH_VALUE;
                        else if (head_item.cls != CLS_NUL &&
                                 id_length_reg < ID_LEN_W'(ID_MAX_CHARS))
                        begin
                            id_chars_next  = {id_chars_reg[ID_W-9:0], head_item.data};
                            id_length_next = id_length_reg + 1'b1;
                        end
                        else
                            id_length_next = ID_LEN_BAD;
                    end
                    PH_VALUE:
                    begin
                        if (head_item.cls == CLS_STAR)
                            line_phase_next = PH_AFTER;
                        else if (head_item.cls == CLS_CLOSE)
                        begin
                            line_phase_next = PH_AFTER;
                            close_seen_next = 1'b1;
                        end
                        else
                        begin
                            if (dot_seen_reg && decimal_count_reg != DEC_MAX)
                                decimal_count_next = decimal_count_reg + 1'b1;
                            if (head_item.cls == CLS_DOT && !dot_seen_reg)
                                dot_seen_next = 1'b1;
                            else
                            begin
                                // Number reader: skip blanks, take a sign, then digits.
                                case (number_phase_reg)
                                    NUM_BEFORE:
                                    begin
                                        if (head_item.cls == CLS_PLUS ||
                                            head_item.cls == CLS_MINUS)
                                        begin
                                            value_negative_next = (head_item.cls == CLS_MINUS);
                                            number_phase_next   = NUM_IN;
                                        end
                                        else if (head_item.cls == CLS_DIGIT)
                                        begin
                                            value_acc_next    = acc_sat ? MAG_LIMIT : acc_added;
                                            number_phase_next = NUM_IN;
                                        end
                                        else if (head_item.cls != CLS_SPACE)
                                            number_phase_next = NUM_STOP;
                                    end
                                    NUM_IN:
                                    begin
                                        if (head_item.cls == CLS_DIGIT)
                                            value_acc_next = acc_sat ? MAG_LIMIT : acc_added;
                                        else
                                            number_phase_next = NUM_STOP;
                                    end
                                    default:
                                    begin
                                        number_phase_next = number_phase_reg;
                                    end
                                endcase
                            end
                        end
                    end
                    PH_AFTER:
                    begin
                        if (head_item.cls == CLS_CLOSE)
                            close_seen_next = 1'b1;
                    end
                    default:
                    begin
                        line_phase_next = line_phase_reg;
                    end
                endcase
            end
        end
    end

    // Output register valid flag.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && is_newline)
            res_valid_next = 1'b1;
        else if (results.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_phase_reg     <= PH_PREFIX;
            id_chars_reg       <= '0;
            id_length_reg      <= '0;
            value_acc_reg      <= '0;
            value_negative_reg <= 1'b0;
            number_phase_reg   <= NUM_BEFORE;
            dot_seen_reg       <= 1'b0;
            decimal_count_reg  <= '0;
            close_seen_reg     <= 1'b0;
            present_bits_reg   <= '0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            line_phase_reg     <= line_phase_next;
            id_chars_reg       <= id_chars_next;
            id_length_reg      <= id_length_next;
            value_acc_reg      <= value_acc_next;
            value_negative_reg <= value_negative_next;
            number_phase_reg   <= number_phase_next;
            dot_seen_reg       <= dot_seen_next;
            decimal_count_reg  <= decimal_count_next;
            close_seen_reg     <= close_seen_next;
            present_bits_reg   <= present_bits_next;
            res_valid_reg      <= res_valid_next;
        end
    end

    // Result payload, loaded at each newline.
    always_ff @(posedge clk)
    begin
        if (pop && is_newline)
        begin
            res_matched_reg  <= hit;
            res_channel_reg  <= hit ? slot : 2'd0;
            res_reading_reg  <= hit ? reading : 32'd0;
            res_decimals_reg <= hit ? decimal_count_reg : 4'd0;
            res_mask_reg     <= 4'(present_bits_next);
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.line_matched = res_matched_reg;
    assign results.channel      = res_channel_reg;
    assign results.reading      = res_reading_reg;
    assign results.decimals     = res_decimals_reg;
    assign results.present_mask = res_mask_reg;

    // The identifier length is either a real count or the overflow mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        id_length_reg <= ID_LEN_W'(ID_MAX_CHARS) || id_length_reg == ID_LEN_BAD)
        else $error("identifier length out of range");

    // Decimals are only counted after the point.
    assert property (@(posedge clk) disable iff (!rst_n)
        decimal_count_reg != '0 |-> dot_seen_reg)
        else $error("decimals counted without a point");

    // A closing bracket is only recorded once the value has ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        close_seen_reg |-> line_phase_reg == PH_AFTER)
        else $error("close seen outside the after-value phase");

    // The magnitude never exceeds its saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        value_acc_reg <= MAG_LIMIT)
        else $error("value magnitude above limit");

endmodule

`default_nettype wire

// File: rtl/meter_data_line_parser.sv
// A newline byte is queued and then registered as a result. Throughput: one data byte
// per cycle while the queue has room; the parser updates its line state once per byte.
// A four-item queue separates the byte input from the parser, so a stalled result only
// blocks input once the queue has filled; configuration writes are taken every cycle.
// Reset (rst_n low, asynchronous) clears code slots, slot count, line state and mask.
`default_nettype none

module meter_data_line_parser
    import mdlp_pkg::*;
(
    input  wire              clk,
    input  wire              rst_n,
    mdlp_byte_if.sink        bytes_in,
    mdlp_cfg_if.sink         cfg,
    mdlp_result_if.source    results
);

    logic       push_valid, push_ready;
    byte_item_t push_item;
    logic       head_valid, head_ready;
    byte_item_t head_item;

    // Byte classification.
    mdlp_front u_front (
        .bytes_in   (bytes_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between front and parser.
    mdlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    // Line parser and result register.
    mdlp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_item  (head_item),
        .cfg        (cfg),
        .results    (results)
    );

endmodule

`default_nettype wire

// File: bench/meter_data_line_parser_test.sv
// Self-checking testbench of the meter data-line parser: directed lines, random lines and idling.
`timescale 1ns / 1ps

module meter_data_line_parser_test;
    import mdlp_pkg::*;

    // Expected outcome of one newline.
    typedef struct packed {
        logic        matched;
        logic [1:0]  chan;
        logic [31:0] reading;
        logic [3:0]  decimals;
        logic [3:0]  mask;
    } line_result_t;

    // A directed line may carry a result typed in by hand.
    typedef struct packed {
        logic         typed;
        line_result_t want;
    } typed_line_t;

    typedef struct {
        string        text;
        logic         typed;
        line_result_t want;
    } dir_row_t;

    typedef logic [7:0] byte_q_t [$];

    localparam int CLK_HALF       = 4;
    localparam int SETTINGS_RUN   = 8;
    localparam int BYTES_PER_SET  = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 4;
    localparam logic [7:0] NUL_MARK = "^";

    // Slot counts of each setting, the extremes among them.
    localparam int COUNT_PLAN [SETTINGS_RUN] = '{4, 0, 7, 1, 2, 3, 4, 5};

    localparam string PREFIX_POOL = "0123456789-AB )*.";
    localparam string ID_POOL     = "0123456789.ABCxyz:*)";
    localparam string BLANK_POOL  = " \011\013\014\015";
    localparam string BREAK_POOL  = ":()*.\000\377";
    localparam string UNIT_POOL   = "kWhVAr";

    // Directed lines; a caret stands for a zero byte.
    dir_row_t dir_rows [21] = '{
        '{"(1-0:1.8.0(5)",            1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"abc",                      1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"",                         1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"x:1.8.0(12",               1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"x:ABCDEFGHI(1)",           1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"x:1.8^(1)",                1'b1, '{1'b0, 2'd0, 32'd0, 4'd0, 4'h0}},
        '{"1-0:1.8.0(001234.567*kWh)", 1'b0, '0},
        '{")x:2.8.0(-42)",            1'b0, '0},
        '{"x:2.8.0(7*kW)h)",          1'b0, '0},
        '{"x:2.8.0(7)*x",             1'b0, '0},
        '{"x:(  +0099.5*V)",          1'b0, '0},
        '{"x:ABCDEFGH(2147483647)",   1'b1, '{1'b1, 2'd3, 32'h7FFF_FFFF, 4'd0, 4'hF}},
        '{"x:ABCDEFGH(2147483648)",   1'b1, '{1'b1, 2'd3, 32'h7FFF_FFFF, 4'd0, 4'hF}},
        '{"x:ABCDEFGH(-2147483648)",  1'b1, '{1'b1, 2'd3, 32'h8000_0000, 4'd0, 4'hF}},
        '{"x:ABCDEFGH(-99999999999)", 1'b1, '{1'b1, 2'd3, 32'h8000_0000, 4'd0, 4'hF}},
        '{"x:1.8.0(\011\013\014\015 12a34)", 1'b0, '0},
        '{"x:1.8.0(.1234567890123456789)", 1'b1, '{1'b1, 2'd0, 32'h7FFF_FFFF, 4'd15, 4'hF}},
        '{"x:1.8.0(1.2.3)",           1'b0, '0},
        '{"x:1.8.0(- 5)",             1'b0, '0},
        '{"x:1.8.0(\3779)",           1'b0, '0},
        '{"x:1.8.0()",                1'b0, '0}
    };

    logic clk;
    logic rst_n;

    mdlp_byte_if   byte_ch ();
    mdlp_cfg_if    cfg_ch ();
    mdlp_result_if res_ch ();

    meter_data_line_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .bytes_in (byte_ch),
        .cfg      (cfg_ch),
        .results  (res_ch)
    );

    // Predicted parser state and configuration.
    logic [2:0]    slot_count = '0;
    logic [63:0]   code_slot [CODE_SLOTS] = '{default: '0};
    line_phase_t   line_at = PH_PREFIX;
    number_phase_t num_at = NUM_BEFORE;
    logic [63:0]   id_chars = '0;
    logic [3:0]    id_len = '0;
    logic [31:0]   num_acc = '0;
    logic          num_neg = 1'b0;
    logic          dot_seen = 1'b0;
    logic [3:0]    dec_count = '0;
    logic          close_seen = 1'b0;
    logic [3:0]    seen_slots = '0;

    line_result_t pending_lines [$];
    typed_line_t  directed_lines [$];
    line_result_t line_want;
    typed_line_t  line_typed;

    byte_q_t slot_ids [CODE_SLOTS];
    byte_q_t line_buf;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int bytes_taken = 0;
    int lines_checked = 0;
    int matched_lines = 0;
    int quiet_cycles = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Adds one decimal digit to the magnitude, saturating at the limit.
    function automatic void add_digit(input logic [31:0] d);
        if (num_acc > (MAG_LIMIT - d) / 32'd10)
            num_acc = MAG_LIMIT;
        else
            num_acc = num_acc * 32'd10 + d;
    endfunction

    // Advances the predicted line state by one byte and queues the outcome of a newline.
    function automatic void parse_meter_byte(input logic [7:0] b);
        logic         is_digit;
        logic         hit;
        logic [1:0]   slot;
        int           used;
        line_result_t outcome;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        if (b == CH_NEWLINE)
        begin
            used = (slot_count > CODE_SLOTS) ? CODE_SLOTS : int'(slot_count);
            hit = 1'b0;
            slot = '0;
            if (close_seen && id_len <= ID_MAX_CHARS)
            begin
                for (int i = 0; i < used; i++)
                begin
                    if (!hit && code_slot[i] == id_chars)
                    begin
                        hit = 1'b1;
                        slot = 2'(i);
                    end
                end
            end
            outcome = '0;
            if (hit)
            begin
                seen_slots = seen_slots | (4'b1 << slot);
                outcome.matched = 1'b1;
                outcome.chan = slot;
                if (num_neg)
                    outcome.reading = 32'd0 - num_acc;
                else
                    outcome.reading = (num_acc > POS_MAX) ? POS_MAX : num_acc;
                outcome.decimals = dec_count;
            end
            outcome.mask = seen_slots;
            pending_lines.push_back(outcome);
            line_at = PH_PREFIX;
            num_at = NUM_BEFORE;
            id_chars = '0;
            id_len = '0;
            num_acc = '0;
            num_neg = 1'b0;
            dot_seen = 1'b0;
            dec_count = '0;
            close_seen = 1'b0;
            return;
        end
        case (line_at)
            PH_PREFIX:
            begin
                if (b == CH_COLON)
                    line_at = PH_ID;
                else if (b == CH_OPEN)
                    line_at = PH_REJECT;
            end
            PH_ID:
            begin
                if (b == CH_OPEN)
                    line_at = PH_VALUE;
                else if (b != CH_NUL && id_len < ID_MAX_CHARS)
                begin
                    id_chars = {id_chars[55:0], b};
                    id_len = id_len + 4'd1;
                end
                else
                    id_len = ID_LEN_BAD;
            end
            PH_VALUE:
            begin
                if (b == CH_STAR)
                    line_at = PH_AFTER;
                else if (b == CH_CLOSE)
                begin
                    line_at = PH_AFTER;
                    close_seen = 1'b1;
                end
                else
                begin
                    if (dot_seen && dec_count < DEC_MAX)
                        dec_count = dec_count + 4'd1;
                    if (b == CH_DOT && !dot_seen)
                        dot_seen = 1'b1;
                    else if (num_at == NUM_BEFORE)
                    begin
                        // Blanks are skipped, a sign or a digit opens the number.
                        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                            num_at = NUM_BEFORE;
                        else if (b == CH_PLUS || b == CH_MINUS)
                        begin
                            num_neg = (b == CH_MINUS);
                            num_at = NUM_IN;
                        end
                        else if (is_digit)
                        begin
                            add_digit(32'(b - CH_ZERO));
                            num_at = NUM_IN;
                        end
                        else
                            num_at = NUM_STOP;
                    end
                    else if (num_at == NUM_IN)
                    begin
                        if (is_digit)
                            add_digit(32'(b - CH_ZERO));
                        else
                            num_at = NUM_STOP;
                    end
                end
            end
            PH_AFTER:
            begin
                if (b == CH_CLOSE)
                    close_seen = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Predicts each accepted item; a directed line may replace the prediction by its typed result.
    always @(posedge clk)
    begin
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            bytes_taken++;
            parse_meter_byte(byte_ch.data_byte);
            if (byte_ch.data_byte == CH_NEWLINE && directed_lines.size() != 0)
            begin
                line_typed = directed_lines.pop_front();
                if (line_typed.typed)
                    pending_lines[pending_lines.size() - 1] = line_typed.want;
            end
        end
    end

    // Mirrors accepted register writes; indexes past the last slot are ignored.
    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            if (cfg_ch.index == CFG_CODE_COUNT)
                slot_count = cfg_ch.data[2:0];
            else if (cfg_ch.index >= CFG_CODE_BASE && cfg_ch.index < CFG_CODE_BASE + CODE_SLOTS)
                code_slot[cfg_ch.index - CFG_CODE_BASE] = cfg_ch.data;
        end
    end

    // Compares each accepted result with the oldest outstanding line.
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_lines.size() == 0)
            begin
                $error("result item with no line outstanding");
                fail_count++;
            end
            else
            begin
                line_want = pending_lines.pop_front();
                lines_checked++;
                if (res_ch.line_matched)
                    matched_lines++;
                if (res_ch.line_matched !== line_want.matched)
                begin
                    $error("line_matched: expected %0d, actual %0d",
                           line_want.matched, res_ch.line_matched);
                    fail_count++;
                end
                if (res_ch.channel !== line_want.chan)
                begin
                    $error("channel: expected %0d, actual %0d", line_want.chan, res_ch.channel);
                    fail_count++;
                end
                if (res_ch.reading !== line_want.reading)
                begin
                    $error("reading: expected %0d, actual %0d",
                           $signed(line_want.reading), $signed(res_ch.reading));
                    fail_count++;
                end
                if (res_ch.decimals !== line_want.decimals)
                begin
                    $error("decimals: expected %0d, actual %0d",
                           line_want.decimals, res_ch.decimals);
                    fail_count++;
                end
                if (res_ch.present_mask !== line_want.mask)
                begin
                    $error("present_mask: expected %b, actual %b",
                           line_want.mask, res_ch.present_mask);
                    fail_count++;
                end
            end
        end
    end

    // Result receiver stalls at random.
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("meter_data_line_parser_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offers one data byte, with a random idle gap first, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    // Writes one register and waits until it is taken.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Waits for every outstanding line, then lets queued bytes drain.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes the codes and slot count of one setting and keeps the identifier texts.
    task automatic load_settings(input int setting);
        logic [63:0] code_val [CODE_SLOTS];
        int          pick;
        int          n;
        logic        lead;
        for (int k = 0; k < CODE_SLOTS; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                code_val[k] = '0;
            else if (pick == 1)
                code_val[k] = '1;
            else if (pick == 2)
                code_val[k] = {$urandom, $urandom};
            else if (pick == 3 && k > 0)
                code_val[k] = code_val[k - 1];
            else
            begin
                code_val[k] = '0;
                n = $urandom_range(1, ID_MAX_CHARS);
                repeat (n)
                    code_val[k] = {code_val[k][55:0],
                                   8'(ID_POOL[$urandom_range(0, ID_POOL.len() - 1)])};
            end
        end
        if (setting == 0)
        begin
            code_val[0] = 64'(48'h312E_382E_30);
            code_val[1] = 64'(48'h322E_382E_30);
            code_val[2] = '0;
            code_val[3] = 64'h4142_4344_4546_4748;
        end
        else if (setting == 2)
        begin
            code_val[0] = '1;
            code_val[1] = '0;
        end
        for (int k = 0; k < CODE_SLOTS; k++)
        begin
            write_reg(3'(CFG_CODE_BASE + k), code_val[k]);
            // The identifier text is the code without its leading zero bytes.
            slot_ids[k].delete();
            lead = 1'b1;
            for (int j = 7; j >= 0; j--)
            begin
                if (code_val[k][8 * j +: 8] != CH_NUL)
                    lead = 1'b0;
                if (!lead)
                    slot_ids[k].push_back(code_val[k][8 * j +: 8]);
            end
        end
        write_reg(CFG_CODE_COUNT, {61'({$urandom, $urandom}), 3'(COUNT_PLAN[setting])});
        write_reg(3'(CFG_CODE_BASE + CODE_SLOTS + $urandom_range(0, 2)), {$urandom, $urandom});
        // The write channel goes idle once the last register has been taken.
        cfg_ch.valid <= 1'b0;
    endtask

    // Builds one random line: mostly well formed, some broken, some raw noise.
    task automatic make_random_line();
        int kind;
        int n;
        int pos;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
                line_buf.push_back(PREFIX_POOL[$urandom_range(0, PREFIX_POOL.len() - 1)]);
            line_buf.push_back(CH_COLON);
            if ($urandom_range(0, 99) < 70)
                line_buf = {line_buf, slot_ids[$urandom_range(0, CODE_SLOTS - 1)]};
            else
                repeat ($urandom_range(0, 10))
                    line_buf.push_back(ID_POOL[$urandom_range(0, ID_POOL.len() - 1)]);
            line_buf.push_back(CH_OPEN);
            repeat ($urandom_range(0, 2))
                line_buf.push_back(BLANK_POOL[$urandom_range(0, BLANK_POOL.len() - 1)]);
            case ($urandom_range(0, 2))
                1: line_buf.push_back(CH_PLUS);
                2: line_buf.push_back(CH_MINUS);
                default:
                begin
                end
            endcase
            // Digits with an optional point; a few long runs reach saturation.
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 7);
            pos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pos)
                    line_buf.push_back(CH_DOT);
                line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            if (pos == n)
                line_buf.push_back(CH_DOT);
            if ($urandom_range(0, 99) < 60)
            begin
                line_buf.push_back(CH_CLOSE);
                if ($urandom_range(0, 99) < 30)
                begin
                    line_buf.push_back(CH_STAR);
                    line_buf.push_back(UNIT_POOL[$urandom_range(0, UNIT_POOL.len() - 1)]);
                end
            end
            else
            begin
                line_buf.push_back(CH_STAR);
                line_buf.push_back(UNIT_POOL[$urandom_range(0, UNIT_POOL.len() - 1)]);
                line_buf.push_back(CH_CLOSE);
            end
            // Broken lines get one byte replaced by a delimiter or an odd byte.
            if (kind >= 70)
            begin
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = BREAK_POOL[$urandom_range(0, BREAK_POOL.len() - 1)];
            end
        end
        line_buf.push_back(CH_NEWLINE);
    endtask

    // Reset, then one phase per setting, each with one of four idling patterns.
    initial
    begin
        int          sent;
        logic [7:0]  ch;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int setting = 0; setting < SETTINGS_RUN; setting++)
        begin
            case (setting % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 48; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 48; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            if (setting > 0)
                settle();
            load_settings(setting);

            // Directed lines come first, under the first setting.
            if (setting == 0)
            begin
                for (int r = 0; r < $size(dir_rows); r++)
                begin
                    directed_lines.push_back('{dir_rows[r].typed, dir_rows[r].want});
                    for (int i = 0; i < dir_rows[r].text.len(); i++)
                    begin
                        ch = dir_rows[r].text[i];
                        send_byte((ch == NUL_MARK) ? CH_NUL : ch);
                    end
                    send_byte(CH_NEWLINE);
                end
            end

            sent = 0;
            while (sent < BYTES_PER_SET)
            begin
                make_random_line();
                foreach (line_buf[i])
                    send_byte(line_buf[i]);
                sent += line_buf.size();
            end
        end
        settle();

        if (pending_lines.size() != 0)
        begin
            $error("%0d lines never produced a result", pending_lines.size());
            fail_count++;
        end
        $display("Run covered %0d bytes and %0d lines (%0d matched) over %0d settings,",
                 bytes_taken, lines_checked, matched_lines, SETTINGS_RUN);
        $display("with sender gaps and receiver stalls in turn; %0d mismatches.", fail_count);
        if (fail_count == 0)
            $display("meter_data_line_parser_test: PASS");
        else
            $display("meter_data_line_parser_test: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/mdlp_pkg.sv
rtl/mdlp_byte_if.sv
rtl/mdlp_result_if.sv
rtl/mdlp_cfg_if.sv
rtl/mdlp_front.sv
rtl/mdlp_queue.sv
rtl/mdlp_back.sv
rtl/meter_data_line_parser.sv
bench/meter_data_line_parser_test.sv
